/* rtl/core/ftq_pkg.sv */
// Shared types, codes and default sizes of the fat tree usage and quota table.
package ftq_pkg;

    localparam int HOST_COUNT_DEF   = 64;
    localparam int SWITCH_COUNT_DEF = 256;
    localparam int LINK_COUNT_DEF   = 1024;
    localparam int MAX_LEVELS_DEF   = 3;

    localparam int USAGE_W     = 8;
    localparam int FANOUT_W    = 7;
    localparam int HEIGHT_W    = 2;
    localparam int ACTION_W    = 4;
    localparam int INDEX_W     = 10;
    localparam int STATUS_W    = 2;
    localparam int FRAG_W      = 7;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    localparam logic [USAGE_W-1:0] USAGE_MAX = 8'hFF;
    localparam logic [FRAG_W-1:0]  FRAG_MAX  = 7'd127;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ALLOC_SWITCH = 4'd0,
        ACT_FREE_SWITCH  = 4'd1,
        ACT_ALLOC_HOST   = 4'd2,
        ACT_FREE_HOST    = 4'd3,
        ACT_ALLOC_LINK   = 4'd4,
        ACT_FREE_LINK    = 4'd5,
        ACT_CHECK_SWITCH = 4'd6,
        ACT_CHECK_LINK   = 4'd7,
        ACT_COUNT_FRAG   = 4'd8
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_QUOTA = 2'd1,
        STATUS_ZERO  = 2'd2
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_NODE_QUOTA   = 3'd0,
        CFG_LINK_QUOTA   = 3'd1,
        CFG_TREE_HEIGHT  = 3'd2,
        CFG_FANOUT_ONE   = 3'd3,
        CFG_FANOUT_TWO   = 3'd4,
        CFG_FANOUT_THREE = 3'd5
    } cfg_index_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_UPDATE,
        S_SCAN,
        S_DIVIDE,
        S_NEXT,
        S_RESULT
    } state_t;

endpackage

/* rtl/core/ftq_div.sv */
// Restoring divider that yields one quotient bit per cycle.
module ftq_div #(
    parameter int NUM_W = 7,
    parameter int DEN_W = 7
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] quot_reg, quot_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;

    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             ge;

    // One shift and trial subtraction per cycle.
    assign shifted = {rem_reg, quot_reg[NUM_W-1]};
    assign ge      = shifted >= {1'b0, den_reg};
    assign diff    = shifted - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            quot_next = num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            quot_next = {quot_reg[NUM_W-2:0], ge};
            rem_next  = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

/* rtl/core/fat_tree_usage_quota_table.sv */
// Top level of the fat tree usage and quota table.
//
//   Channel  Handshake              Beat contents
//   in       in_valid / in_stall    action, element_index, want_free, last_of_group
//   out      out_valid / out_stall  status, conflict, fragment_count
//   cfg      cfg_we                 cfg_index, cfg_wdata
//
// Counter actions and checks pass through accept, memory read, update and result steps.
// A fragment query scans one host bit per cycle for each pod visited and uses the
// shared divider to size the subpods of each mixed pod above level zero.
// After reset a clearing pass over every address zeroes the counter memories; no
// beat is taken meanwhile. A result that waits on out_stall holds the block in its
// result step.
module fat_tree_usage_quota_table #(
    parameter int HOST_COUNT   = ftq_pkg::HOST_COUNT_DEF,
    parameter int SWITCH_COUNT = ftq_pkg::SWITCH_COUNT_DEF,
    parameter int LINK_COUNT   = ftq_pkg::LINK_COUNT_DEF,
    parameter int MAX_LEVELS   = ftq_pkg::MAX_LEVELS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [ftq_pkg::ACTION_W-1:0]       action,
    input  logic [ftq_pkg::INDEX_W-1:0]        element_index,
    input  logic                               want_free,
    input  logic                               last_of_group,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [ftq_pkg::STATUS_W-1:0]       status,
    output logic                               conflict,
    output logic [ftq_pkg::FRAG_W-1:0]         fragment_count,
    input  logic                               cfg_we,
    input  logic [ftq_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ftq_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int UW   = ftq_pkg::USAGE_W;
    localparam int FW   = ftq_pkg::FANOUT_W;
    localparam int RW   = ftq_pkg::FRAG_W;
    localparam int HW   = $clog2(HOST_COUNT + 1);
    localparam int HIW  = $clog2(HOST_COUNT);
    localparam int SWA  = (SWITCH_COUNT > 1) ? $clog2(SWITCH_COUNT) : 1;
    localparam int LNA  = (LINK_COUNT > 1) ? $clog2(LINK_COUNT) : 1;
    localparam int MAXC0 = (HOST_COUNT > SWITCH_COUNT) ? HOST_COUNT : SWITCH_COUNT;
    localparam int MAXC = (MAXC0 > LINK_COUNT) ? MAXC0 : LINK_COUNT;
    localparam int CW   = $clog2(MAXC);
    localparam int LW   = $clog2(MAX_LEVELS + 2);
    localparam int FIW  = $clog2(MAX_LEVELS + 1);
    localparam int FD   = 2 ** FIW;
    localparam int AW   = ((HW > RW) ? HW : RW) + 1;

    // Control and configuration state.
    ftq_pkg::state_t        state_reg, state_next;
    logic [CW-1:0]          clr_reg, clr_next;
    logic                   gc_reg, gc_next;
    logic [UW-1:0]          node_quota_reg, link_quota_reg;
    logic [ftq_pkg::HEIGHT_W-1:0] tree_height_reg;
    logic [FW-1:0]          fan1_reg, fan2_reg, fan3_reg;
    logic [HOST_COUNT-1:0]  host_used_reg;

    // Latched input beat.
    logic [ftq_pkg::ACTION_W-1:0] act_reg;
    logic [ftq_pkg::INDEX_W-1:0]  idx_reg;
    logic                         wf_reg, last_reg;

    // Pending and presented result.
    logic [ftq_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic                         res_conflict_reg, res_conflict_next;
    logic [RW-1:0]                res_frag_reg, res_frag_next;
    logic                         out_valid_reg, out_valid_next;
    logic [ftq_pkg::STATUS_W-1:0] status_reg, status_next;
    logic                         conflict_reg, conflict_next;
    logic [RW-1:0]                frag_reg, frag_next;

    // Fragment walk state.
    logic [HW-1:0] cb_reg, cb_next;
    logic [HW-1:0] ce_reg, ce_next;
    logic [HW-1:0] pos_reg, pos_next;
    logic [HW-1:0] match_reg, match_next;
    logic [LW-1:0] clvl_reg, clvl_next;
    logic [LW-1:0] plvl_reg, plvl_next;
    logic [RW-1:0] acc_reg, acc_next;
    logic [HW:0]   cursor_reg [FD];
    logic [HW-1:0] fend_reg [FD];
    logic [HW-1:0] fsub_reg [FD];

    // Counter memories.
    logic [UW-1:0] sw_mem [SWITCH_COUNT];
    logic [UW-1:0] hs_mem [HOST_COUNT];
    logic [UW-1:0] ln_mem [LINK_COUNT];
    logic [UW-1:0] sw_rd_reg, hs_rd_reg, ln_rd_reg;
    logic          sw_we, hs_we, ln_we;
    logic [SWA-1:0] sw_wa;
    logic [HIW-1:0] hs_wa;
    logic [LNA-1:0] ln_wa;
    logic [UW-1:0]  mem_wd;

    logic [31:0]    idx_ext, clr_ext;
    logic [SWA-1:0] sw_addr;
    logic [HIW-1:0] hs_addr;
    logic [LNA-1:0] ln_addr;
    logic           sw_in, hs_in, ln_in;

    logic           in_accept;
    logic [LW-1:0]  top_lvl;
    logic [FW-1:0]  fan_sel;
    logic           bit_used, hit_m;
    logic [HW-1:0]  match_n, pos_n, pod_size;
    logic           scan_last, uniform;
    logic [HW-1:0]  add_val;
    logic           add_en;
    logic [AW-1:0]  acc_sum;
    logic [RW-1:0]  acc_sat;
    logic [FIW-1:0] pidx, cidx;
    logic [HW:0]    fcur, csum;
    logic [HW-1:0]  fend, fsub, cend;
    logic           have_child, plvl_over;
    logic           fw_en, cur_upd;
    logic           div_start, div_done;
    logic [HW-1:0]  div_quot;
    logic [UW-1:0]  cur_val, quota_sel;
    logic           out_free;

    assign in_accept = in_valid && (state_reg == ftq_pkg::S_IDLE);
    assign in_stall  = (state_reg != ftq_pkg::S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;

    // Element addressing and range checks.
    assign idx_ext = 32'(idx_reg);
    assign clr_ext = 32'(clr_reg);
    assign sw_addr = idx_ext[SWA-1:0];
    assign hs_addr = idx_ext[HIW-1:0];
    assign ln_addr = idx_ext[LNA-1:0];
    assign sw_in   = idx_ext < 32'(SWITCH_COUNT);
    assign hs_in   = idx_ext < 32'(HOST_COUNT);
    assign ln_in   = idx_ext < 32'(LINK_COUNT);

    // Starting level of the walk and the fanout of the current level.
    assign top_lvl = (32'(tree_height_reg) > 32'(MAX_LEVELS)) ? LW'(MAX_LEVELS)
                                                               : LW'(tree_height_reg);
    always_comb
    begin
        priority if (clvl_reg == LW'(1))
            fan_sel = fan1_reg;
        else if (clvl_reg == LW'(2))
            fan_sel = fan2_reg;
        else if (clvl_reg == LW'(3))
            fan_sel = fan3_reg;
        else
            fan_sel = FW'(1);
        if (fan_sel == '0)
            fan_sel = FW'(1);
    end

    // Host scan: one bit per cycle.
    assign bit_used  = host_used_reg[pos_reg[HIW-1:0]];
    assign hit_m     = (~bit_used) == wf_reg;
    assign match_n   = match_reg + HW'(hit_m);
    assign pos_n     = pos_reg + HW'(1);
    assign scan_last = (pos_n == ce_reg);
    assign pod_size  = ce_reg - cb_reg;
    assign uniform   = (match_n == '0) || (match_n == pod_size);

    // Saturating fragment accumulator.
    assign acc_sum = AW'(acc_reg) + AW'(add_val);
    assign acc_sat = (acc_sum > AW'(ftq_pkg::FRAG_MAX)) ? ftq_pkg::FRAG_MAX
                                                         : acc_sum[RW-1:0];

    // Child stepping of the parent frame.
    assign pidx       = plvl_reg[FIW-1:0];
    assign cidx       = clvl_reg[FIW-1:0];
    assign fcur       = cursor_reg[pidx];
    assign fend       = fend_reg[pidx];
    assign fsub       = fsub_reg[pidx];
    assign csum       = fcur + (HW+1)'(fsub);
    assign cend       = (csum > (HW+1)'(fend)) ? fend : csum[HW-1:0];
    assign have_child = fcur < (HW+1)'(fend);
    assign plvl_over  = plvl_reg > top_lvl;

    ftq_div #(
        .NUM_W (HW),
        .DEN_W (FW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (pod_size),
        .den      (fan_sel),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Counter value and quota for the latched action.
    always_comb
    begin
        cur_val   = '0;
        quota_sel = node_quota_reg;
        unique case (act_reg)
            ftq_pkg::ACT_ALLOC_SWITCH, ftq_pkg::ACT_FREE_SWITCH,
            ftq_pkg::ACT_CHECK_SWITCH:
            begin
                cur_val = sw_rd_reg;
            end
            ftq_pkg::ACT_ALLOC_HOST, ftq_pkg::ACT_FREE_HOST:
            begin
                cur_val = hs_rd_reg;
            end
            ftq_pkg::ACT_ALLOC_LINK, ftq_pkg::ACT_FREE_LINK,
            ftq_pkg::ACT_CHECK_LINK:
            begin
                cur_val   = ln_rd_reg;
                quota_sel = link_quota_reg;
            end
            default:
            begin
                cur_val = '0;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ftq_pkg::S_CLEAR:
                if (clr_reg == CW'(MAXC - 1))
                    state_next = ftq_pkg::S_IDLE;
            ftq_pkg::S_IDLE:
                if (in_valid)
                    state_next = (action == ftq_pkg::ACT_COUNT_FRAG) ? ftq_pkg::S_SCAN
                                                                      : ftq_pkg::S_READ;
            ftq_pkg::S_READ:
                state_next = ftq_pkg::S_UPDATE;
            ftq_pkg::S_UPDATE:
                state_next = ftq_pkg::S_RESULT;
            ftq_pkg::S_SCAN:
                if (scan_last)
                    state_next = (uniform || clvl_reg == '0) ? ftq_pkg::S_NEXT
                                                              : ftq_pkg::S_DIVIDE;
            ftq_pkg::S_DIVIDE:
                if (div_done)
                    state_next = ftq_pkg::S_NEXT;
            ftq_pkg::S_NEXT:
                if (plvl_over)
                    state_next = ftq_pkg::S_RESULT;
                else if (have_child)
                    state_next = ftq_pkg::S_SCAN;
            ftq_pkg::S_RESULT:
                if (out_free)
                    state_next = ftq_pkg::S_IDLE;
            default:
                state_next = ftq_pkg::S_CLEAR;
        endcase
    end

    // Datapath controls and next values.
    always_comb
    begin
        clr_next          = clr_reg;
        gc_next           = gc_reg;
        res_status_next   = res_status_reg;
        res_conflict_next = res_conflict_reg;
        res_frag_next     = res_frag_reg;
        out_valid_next    = out_valid_reg;
        status_next       = status_reg;
        conflict_next     = conflict_reg;
        frag_next         = frag_reg;
        cb_next           = cb_reg;
        ce_next           = ce_reg;
        pos_next          = pos_reg;
        match_next        = match_reg;
        clvl_next         = clvl_reg;
        plvl_next         = plvl_reg;
        acc_next          = acc_reg;
        add_val           = '0;
        add_en            = 1'b0;
        fw_en             = 1'b0;
        cur_upd           = 1'b0;
        div_start         = 1'b0;
        sw_we             = 1'b0;
        hs_we             = 1'b0;
        ln_we             = 1'b0;
        sw_wa             = sw_addr;
        hs_wa             = hs_addr;
        ln_wa             = ln_addr;
        mem_wd            = '0;

        // The presented result leaves when taken.
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ftq_pkg::S_CLEAR:
            begin
                clr_next = clr_reg + CW'(1);
                sw_wa    = clr_ext[SWA-1:0];
                hs_wa    = clr_ext[HIW-1:0];
                ln_wa    = clr_ext[LNA-1:0];
                sw_we    = clr_ext < 32'(SWITCH_COUNT);
                hs_we    = clr_ext < 32'(HOST_COUNT);
                ln_we    = clr_ext < 32'(LINK_COUNT);
            end
            ftq_pkg::S_IDLE:
            begin
                cb_next    = '0;
                ce_next    = HW'(HOST_COUNT);
                pos_next   = '0;
                match_next = '0;
                clvl_next  = top_lvl;
                acc_next   = '0;
            end
            ftq_pkg::S_READ:
            begin
                res_status_next   = ftq_pkg::STATUS_DONE;
                res_conflict_next = 1'b0;
                res_frag_next     = '0;
            end
            ftq_pkg::S_UPDATE:
            begin
                unique case (act_reg)
                    ftq_pkg::ACT_ALLOC_SWITCH, ftq_pkg::ACT_ALLOC_HOST,
                    ftq_pkg::ACT_ALLOC_LINK:
                    begin
                        mem_wd = cur_val + UW'(1);
                        if (((act_reg == ftq_pkg::ACT_ALLOC_SWITCH) && !sw_in) ||
                            ((act_reg == ftq_pkg::ACT_ALLOC_HOST) && !hs_in) ||
                            ((act_reg == ftq_pkg::ACT_ALLOC_LINK) && !ln_in) ||
                            ((quota_sel != '0) && (cur_val >= quota_sel)) ||
                            (cur_val == ftq_pkg::USAGE_MAX))
                        begin
                            res_status_next = ftq_pkg::STATUS_QUOTA;
                        end
                        else
                        begin
                            sw_we = (act_reg == ftq_pkg::ACT_ALLOC_SWITCH);
                            hs_we = (act_reg == ftq_pkg::ACT_ALLOC_HOST);
                            ln_we = (act_reg == ftq_pkg::ACT_ALLOC_LINK);
                        end
                    end
                    ftq_pkg::ACT_FREE_SWITCH, ftq_pkg::ACT_FREE_HOST,
                    ftq_pkg::ACT_FREE_LINK:
                    begin
                        mem_wd = cur_val - UW'(1);
                        if (((act_reg == ftq_pkg::ACT_FREE_SWITCH) && !sw_in) ||
                            ((act_reg == ftq_pkg::ACT_FREE_HOST) && !hs_in) ||
                            ((act_reg == ftq_pkg::ACT_FREE_LINK) && !ln_in) ||
                            (cur_val == '0))
                        begin
                            res_status_next = ftq_pkg::STATUS_ZERO;
                        end
                        else
                        begin
                            sw_we = (act_reg == ftq_pkg::ACT_FREE_SWITCH);
                            hs_we = (act_reg == ftq_pkg::ACT_FREE_HOST);
                            ln_we = (act_reg == ftq_pkg::ACT_FREE_LINK);
                        end
                    end
                    ftq_pkg::ACT_CHECK_SWITCH, ftq_pkg::ACT_CHECK_LINK:
                    begin
                        // Group result is ORed until the last check of the group.
                        res_conflict_next = gc_reg ||
                            (((act_reg == ftq_pkg::ACT_CHECK_SWITCH) ? sw_in : ln_in) &&
                             (quota_sel != '0) && (cur_val >= quota_sel));
                        gc_next = last_reg ? 1'b0 : res_conflict_next;
                    end
                    default:
                    begin
                        res_status_next = ftq_pkg::STATUS_DONE;
                    end
                endcase
            end
            ftq_pkg::S_SCAN:
            begin
                pos_next   = pos_n;
                match_next = match_n;
                if (scan_last)
                begin
                    plvl_next = clvl_reg + LW'(1);
                    if (match_n == '0)
                    begin
                        add_en = 1'b0;
                    end
                    else if (match_n == pod_size)
                    begin
                        add_en  = 1'b1;
                        add_val = HW'(1);
                    end
                    else if (clvl_reg == '0)
                    begin
                        add_en  = 1'b1;
                        add_val = match_n;
                    end
                    else
                    begin
                        div_start = 1'b1;
                    end
                end
            end
            ftq_pkg::S_DIVIDE:
            begin
                if (div_done)
                begin
                    if (div_quot == '0)
                    begin
                        // Subpods would be empty: count matching hosts one by one.
                        add_en    = 1'b1;
                        add_val   = match_reg;
                        plvl_next = clvl_reg + LW'(1);
                    end
                    else
                    begin
                        fw_en     = 1'b1;
                        plvl_next = clvl_reg;
                    end
                end
            end
            ftq_pkg::S_NEXT:
            begin
                if (plvl_over)
                begin
                    res_status_next   = ftq_pkg::STATUS_DONE;
                    res_conflict_next = 1'b0;
                    res_frag_next     = acc_reg;
                end
                else if (have_child)
                begin
                    cur_upd    = 1'b1;
                    cb_next    = fcur[HW-1:0];
                    ce_next    = cend;
                    pos_next   = fcur[HW-1:0];
                    match_next = '0;
                    clvl_next  = plvl_reg - LW'(1);
                end
                else
                begin
                    plvl_next = plvl_reg + LW'(1);
                end
            end
            ftq_pkg::S_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    conflict_next  = res_conflict_reg;
                    frag_next      = res_frag_reg;
                end
            end
            default:
            begin
                clr_next = clr_reg;
            end
        endcase

        if (add_en)
            acc_next = acc_sat;
    end

    // Control registers with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ftq_pkg::S_CLEAR;
            clr_reg         <= '0;
            gc_reg          <= 1'b0;
            out_valid_reg   <= 1'b0;
            node_quota_reg  <= '0;
            link_quota_reg  <= '0;
            tree_height_reg <= 2'd3;
            fan1_reg        <= FW'(4);
            fan2_reg        <= FW'(4);
            fan3_reg        <= FW'(4);
            host_used_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            gc_reg        <= gc_next;
            out_valid_reg <= out_valid_next;
            if (hs_we && (state_reg == ftq_pkg::S_UPDATE))
                host_used_reg[hs_wa] <= (mem_wd != '0);
            if (cfg_we)
            begin
                unique case (cfg_index)
                    ftq_pkg::CFG_NODE_QUOTA:   node_quota_reg  <= cfg_wdata;
                    ftq_pkg::CFG_LINK_QUOTA:   link_quota_reg  <= cfg_wdata;
                    ftq_pkg::CFG_TREE_HEIGHT:  tree_height_reg <= cfg_wdata[1:0];
                    ftq_pkg::CFG_FANOUT_ONE:   fan1_reg        <= cfg_wdata[FW-1:0];
                    ftq_pkg::CFG_FANOUT_TWO:   fan2_reg        <= cfg_wdata[FW-1:0];
                    ftq_pkg::CFG_FANOUT_THREE: fan3_reg        <= cfg_wdata[FW-1:0];
                    default:                   node_quota_reg  <= node_quota_reg;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            act_reg  <= action;
            idx_reg  <= element_index;
            wf_reg   <= want_free;
            last_reg <= last_of_group;
        end
        res_status_reg   <= res_status_next;
        res_conflict_reg <= res_conflict_next;
        res_frag_reg     <= res_frag_next;
        status_reg       <= status_next;
        conflict_reg     <= conflict_next;
        frag_reg         <= frag_next;
        cb_reg           <= cb_next;
        ce_reg           <= ce_next;
        pos_reg          <= pos_next;
        match_reg        <= match_next;
        clvl_reg         <= clvl_next;
        plvl_reg         <= plvl_next;
        acc_reg          <= acc_next;
        if (fw_en)
        begin
            cursor_reg[cidx] <= {1'b0, cb_reg};
            fend_reg[cidx]   <= ce_reg;
            fsub_reg[cidx]   <= div_quot;
        end
        if (cur_upd)
            cursor_reg[pidx] <= csum;
    end

    // Counter memories: one write and one registered read each.
    always_ff @(posedge clk)
    begin
        if (sw_we)
            sw_mem[sw_wa] <= mem_wd;
        sw_rd_reg <= sw_mem[sw_addr];
    end

    always_ff @(posedge clk)
    begin
        if (hs_we)
            hs_mem[hs_wa] <= mem_wd;
        hs_rd_reg <= hs_mem[hs_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ln_we)
            ln_mem[ln_wa] <= mem_wd;
        ln_rd_reg <= ln_mem[ln_addr];
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign conflict       = conflict_reg;
    assign fragment_count = frag_reg;

endmodule

/* verif/tb.sv */
// Self-checking testbench for the fat tree usage and quota table.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ftq_pkg::*;

    localparam int HOSTS      = HOST_COUNT_DEF;
    localparam int SWITCHES   = SWITCH_COUNT_DEF;
    localparam int LINKS      = LINK_COUNT_DEF;
    localparam int LEVELS     = MAX_LEVELS_DEF;
    localparam int IDLE_LIMIT = 6000;
    localparam int RANDOM_ITEMS = 1300;

    // Range of action codes that the block must ignore.
    localparam logic [ACTION_W-1:0] ACT_UNUSED_LO = 4'd9;
    localparam logic [ACTION_W-1:0] ACT_UNUSED_HI = 4'd15;

    typedef struct packed {
        logic [STATUS_W-1:0] st;
        logic                cf;
        logic [FRAG_W-1:0]   fc;
    } answer_t;

    typedef struct {
        bit                  is_cfg;
        logic [ACTION_W-1:0] act;
        logic [INDEX_W-1:0]  idx;
        bit                  wf;
        bit                  last;
        bit                  typed;
        answer_t             ans;
    } row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic [ACTION_W-1:0]     action;
    logic [INDEX_W-1:0]      element_index;
    logic                    want_free;
    logic                    last_of_group;
    logic                    out_valid;
    logic                    out_stall;
    logic [STATUS_W-1:0]     status;
    logic                    conflict;
    logic [FRAG_W-1:0]       fragment_count;
    logic                    cfg_we;
    logic [CFG_INDEX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_wdata;

    // Shadow copy of the table and its registers.
    logic [USAGE_W-1:0]  host_use [HOSTS];
    logic [USAGE_W-1:0]  switch_use [SWITCHES];
    logic [USAGE_W-1:0]  link_use [LINKS];
    bit                  group_hit;
    logic [USAGE_W-1:0]  node_limit;
    logic [USAGE_W-1:0]  link_limit;
    logic [HEIGHT_W-1:0] height;
    logic [FANOUT_W-1:0] fanout [1:3];

    answer_t pending_answers [$];
    int      error_count;
    int      beats_in;
    int      beats_out;
    int      frag_queries;
    int      refusals;
    int      idle_cycles;
    bit      calm;
    bit      hold_request;

    fat_tree_usage_quota_table uut (.*);

    always #4 clk = ~clk;

    // Fragment walk over the shadow host counters.
    function automatic int unsigned frag_pod(bit wf, int unsigned b, int unsigned sz,
                                             int unsigned lvl);
        bit          all_free;
        bit          all_used;
        int unsigned sub;
        int unsigned sum;
        int unsigned f;
        int unsigned len;
        all_free = 1;
        all_used = 1;
        sum = 0;
        for (int unsigned i = b; i < b + sz && i < HOSTS; i++)
        begin
            if (host_use[i] == 0) all_used = 0;
            else all_free = 0;
        end
        if (all_free) return wf ? 1 : 0;
        if (all_used) return wf ? 0 : 1;
        f = (lvl >= 1 && lvl <= 3) ? fanout[lvl] : 1;
        if (f == 0) f = 1;
        sub = (lvl == 0) ? 0 : sz / f;
        if (sub == 0)
        begin
            for (int unsigned i = b; i < b + sz && i < HOSTS; i++)
                if ((host_use[i] == 0) == wf) sum++;
            return sum;
        end
        for (int unsigned i = b; i < b + sz; i += sub)
        begin
            len = sub;
            if (len > b + sz - i) len = b + sz - i;
            sum += frag_pod(wf, i, len, lvl - 1);
        end
        return sum;
    endfunction

    // Applies one beat to the shadow table and returns the answer it should produce.
    function automatic answer_t apply_action(logic [ACTION_W-1:0] act,
                                             logic [INDEX_W-1:0] idx, bit wf, bit last);
        answer_t     a;
        bit          hit;
        int unsigned lvl;
        int unsigned n;
        a = '0;
        case (act)
            ACT_ALLOC_SWITCH, ACT_ALLOC_HOST, ACT_ALLOC_LINK:
            begin
                logic [USAGE_W-1:0] u;
                logic [USAGE_W-1:0] q;
                n = (act == ACT_ALLOC_SWITCH) ? SWITCHES : (act == ACT_ALLOC_HOST) ? HOSTS : LINKS;
                q = (act == ACT_ALLOC_LINK) ? link_limit : node_limit;
                if (idx >= n)
                    a.st = STATUS_QUOTA;
                else
                begin
                    u = (act == ACT_ALLOC_SWITCH) ? switch_use[idx] :
                        (act == ACT_ALLOC_HOST) ? host_use[idx] : link_use[idx];
                    if ((q != 0 && u >= q) || u == USAGE_MAX)
                        a.st = STATUS_QUOTA;
                    else if (act == ACT_ALLOC_SWITCH) switch_use[idx]++;
                    else if (act == ACT_ALLOC_HOST) host_use[idx]++;
                    else link_use[idx]++;
                end
            end
            ACT_FREE_SWITCH, ACT_FREE_HOST, ACT_FREE_LINK:
            begin
                logic [USAGE_W-1:0] u;
                n = (act == ACT_FREE_SWITCH) ? SWITCHES : (act == ACT_FREE_HOST) ? HOSTS : LINKS;
                u = '0;
                if (idx < n)
                    u = (act == ACT_FREE_SWITCH) ? switch_use[idx] :
                        (act == ACT_FREE_HOST) ? host_use[idx] : link_use[idx];
                if (u == 0)
                    a.st = STATUS_ZERO;
                else if (act == ACT_FREE_SWITCH) switch_use[idx]--;
                else if (act == ACT_FREE_HOST) host_use[idx]--;
                else link_use[idx]--;
            end
            ACT_CHECK_SWITCH, ACT_CHECK_LINK:
            begin
                if (act == ACT_CHECK_SWITCH)
                    hit = idx < SWITCHES && node_limit != 0 && switch_use[idx] >= node_limit;
                else
                    hit = idx < LINKS && link_limit != 0 && link_use[idx] >= link_limit;
                group_hit = group_hit | hit;
                a.cf = group_hit;
                if (last) group_hit = 0;
            end
            ACT_COUNT_FRAG:
            begin
                lvl = (height > LEVELS) ? LEVELS : height;
                n = frag_pod(wf, 0, HOSTS, lvl);
                a.fc = FRAG_W'((n > FRAG_MAX) ? FRAG_MAX : n);
            end
            default: ;
        endcase
        return a;
    endfunction

    // One input beat: hold it until the block takes it, then record the expectation.
    task automatic send_beat(logic [ACTION_W-1:0] act, logic [INDEX_W-1:0] idx, bit wf,
                             bit last, bit typed, answer_t typed_ans);
        answer_t a;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        action        <= act;
        element_index <= idx;
        want_free     <= wf;
        last_of_group <= last;
        do @(posedge clk); while (in_stall);
        a = apply_action(act, idx, wf, last);
        if (act == ACT_COUNT_FRAG) frag_queries++;
        pending_answers.push_back(typed ? typed_ans : a);
        beats_in++;
        if (beats_in == 200) hold_request = 1;
    endtask

    // Lets every outstanding result drain so the registers can be rewritten.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t r, logic [CFG_DATA_W-1:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_wdata <= v;
        case (r)
            CFG_NODE_QUOTA:   node_limit = v;
            CFG_LINK_QUOTA:   link_limit = v;
            CFG_TREE_HEIGHT:  height = v[HEIGHT_W-1:0];
            CFG_FANOUT_ONE:   fanout[1] = v[FANOUT_W-1:0];
            CFG_FANOUT_TWO:   fanout[2] = v[FANOUT_W-1:0];
            CFG_FANOUT_THREE: fanout[3] = v[FANOUT_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_all(int nq, int lq, int h, int f1, int f2, int f3);
        write_reg(CFG_NODE_QUOTA, CFG_DATA_W'(nq));
        write_reg(CFG_LINK_QUOTA, CFG_DATA_W'(lq));
        write_reg(CFG_TREE_HEIGHT, CFG_DATA_W'(h));
        write_reg(CFG_FANOUT_ONE, CFG_DATA_W'(f1));
        write_reg(CFG_FANOUT_TWO, CFG_DATA_W'(f2));
        write_reg(CFG_FANOUT_THREE, CFG_DATA_W'(f3));
    endtask

    // Random beat, biased toward a few hot elements so quotas and zero usage are hit.
    task automatic random_beat();
        logic [ACTION_W-1:0] act;
        logic [INDEX_W-1:0]  idx;
        int                  pick;
        pick = $urandom_range(0, 99);
        if (pick < 68) act = ACTION_W'($urandom_range(ACT_ALLOC_SWITCH, ACT_FREE_LINK));
        else if (pick < 86) act = ACTION_W'($urandom_range(ACT_CHECK_SWITCH, ACT_CHECK_LINK));
        else if (pick < 95) act = ACT_COUNT_FRAG;
        else act = ACTION_W'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
        pick = $urandom_range(0, 99);
        if (pick < 55) idx = INDEX_W'($urandom_range(0, 7));
        else if (pick < 90) idx = INDEX_W'($urandom_range(0, HOSTS - 1));
        else idx = INDEX_W'($urandom_range(0, 1023));
        send_beat(act, idx, 1'($urandom_range(0, 1)), $urandom_range(0, 2) == 0, 0, '0);
    endtask

    // Result side: random stall bursts, one long hold-off, no stalls once calm.
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 0;
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
            end
            else if (calm)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                out_stall <= ($urandom_range(0, 2) == 0);
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
        end
    end

    // Result checker: compares each accepted result beat with the oldest expectation.
    always @(posedge clk)
    begin
        answer_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            beats_out++;
            if (pending_answers.size() == 0)
            begin
                $error("result beat with no expectation waiting");
                error_count++;
            end
            else
            begin
                e = pending_answers.pop_front();
                if (status != e.st)
                begin
                    $error("status expected %0d actual %0d", e.st, status);
                    error_count++;
                end
                if (conflict != e.cf)
                begin
                    $error("conflict expected %0d actual %0d", e.cf, conflict);
                    error_count++;
                end
                if (fragment_count != e.fc)
                begin
                    $error("fragment_count expected %0d actual %0d", e.fc, fragment_count);
                    error_count++;
                end
                if (e.st != STATUS_DONE) refusals++;
            end
        end
    end

    // Watchdog on cycles with no beat moving on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("fat_tree_usage_quota_table verification failed");
            $finish;
        end
    end

    // Directed rows; typed answers only where they are obvious.
    function automatic row_t mk(logic [ACTION_W-1:0] act, int idx, bit wf, bit last,
                                bit typed = 0, int st = 0, int cf = 0, int fc = 0);
        row_t r;
        r.is_cfg = 0;
        r.act    = act;
        r.idx    = INDEX_W'(idx);
        r.wf     = wf;
        r.last   = last;
        r.typed  = typed;
        r.ans.st = STATUS_W'(st);
        r.ans.cf = 1'(cf);
        r.ans.fc = FRAG_W'(fc);
        return r;
    endfunction

    row_t directed [$];

    initial
    begin
        clk = 0;
        rst_n = 0;
        in_valid = 0;
        action = '0;
        element_index = '0;
        want_free = 0;
        last_of_group = 0;
        cfg_we = 0;
        cfg_index = '0;
        cfg_wdata = '0;
        calm = 0;
        hold_request = 0;
        error_count = 0;
        beats_in = 0;
        beats_out = 0;
        frag_queries = 0;
        refusals = 0;
        idle_cycles = 0;
        group_hit = 0;
        node_limit = 0;
        link_limit = 0;
        height = 3;
        fanout[1] = 4;
        fanout[2] = 4;
        fanout[3] = 4;
        foreach (host_use[i]) host_use[i] = '0;
        foreach (switch_use[i]) switch_use[i] = '0;
        foreach (link_use[i]) link_use[i] = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Defaults after reset: empty table, unlimited quotas.
        directed.push_back(mk(ACT_COUNT_FRAG, 0, 1, 0, 1, STATUS_DONE, 0, 1));
        directed.push_back(mk(ACT_COUNT_FRAG, 1023, 0, 1, 1, STATUS_DONE, 0, 0));
        directed.push_back(mk(ACT_FREE_SWITCH, 0, 0, 0, 1, STATUS_ZERO));
        directed.push_back(mk(ACT_ALLOC_SWITCH, 1023, 1, 1, 1, STATUS_QUOTA));
        directed.push_back(mk(ACT_FREE_LINK, 1023, 0, 0, 1, STATUS_ZERO));
        directed.push_back(mk(ACT_ALLOC_LINK, 1023, 0, 0, 1, STATUS_DONE));
        directed.push_back(mk(ACT_FREE_LINK, 1023, 0, 0, 1, STATUS_DONE));
        directed.push_back(mk(ACT_ALLOC_HOST, 64, 0, 0, 1, STATUS_QUOTA));
        directed.push_back(mk(ACT_FREE_HOST, 1023, 0, 0, 1, STATUS_ZERO));
        directed.push_back(mk(ACT_ALLOC_HOST, 0, 0, 0));
        directed.push_back(mk(ACT_ALLOC_HOST, 63, 0, 0));
        directed.push_back(mk(ACT_COUNT_FRAG, 0, 1, 0));
        directed.push_back(mk(ACT_COUNT_FRAG, 0, 0, 0));
        directed.push_back(mk(ACT_CHECK_SWITCH, 0, 0, 1, 1, STATUS_DONE, 0, 0));
        directed.push_back(mk(ACT_CHECK_LINK, 1023, 1, 1, 1, STATUS_DONE, 0, 0));
        directed.push_back(mk(ACT_UNUSED_LO, 5, 1, 1, 1, STATUS_DONE, 0, 0));
        directed.push_back(mk(ACT_UNUSED_HI, 1023, 1, 1, 1, STATUS_DONE, 0, 0));
        // Quota of one: refusal, then a group that ORs its conflicts and clears.
        directed.push_back('{is_cfg: 1, default: '0});
        directed.push_back(mk(ACT_ALLOC_SWITCH, 2, 0, 0, 1, STATUS_DONE));
        directed.push_back(mk(ACT_ALLOC_SWITCH, 2, 0, 0, 1, STATUS_QUOTA));
        directed.push_back(mk(ACT_CHECK_SWITCH, 2, 0, 0, 1, STATUS_DONE, 1, 0));
        directed.push_back(mk(ACT_CHECK_LINK, 3, 0, 1, 1, STATUS_DONE, 1, 0));
        directed.push_back(mk(ACT_CHECK_SWITCH, 256, 0, 1, 1, STATUS_DONE, 0, 0));
        directed.push_back(mk(ACT_FREE_SWITCH, 2, 0, 0, 1, STATUS_DONE));
        directed.push_back(mk(ACT_COUNT_FRAG, 0, 0, 0));

        foreach (directed[i])
        begin
            if (directed[i].is_cfg)
            begin
                drain();
                write_all(1, 1, 1, 64, 1, 1);
            end
            else
                send_beat(directed[i].act, directed[i].idx, directed[i].wf,
                          directed[i].last, directed[i].typed, directed[i].ans);
        end

        // Counter saturation with unlimited quota, then twelve frees from the saturated count.
        drain();
        write_all(0, 0, 3, 4, 4, 4);
        repeat (258) send_beat(ACT_ALLOC_LINK, 7, 0, 0, 0, '0);
        repeat (12) send_beat(ACT_FREE_LINK, 7, 0, 0, 0, '0);

        // Random phases, each with its own register setting; extremes come first.
        for (int ph = 0; ph < 8; ph++)
        begin
            drain();
            case (ph)
                0: write_all(255, 255, 3, 1, 1, 1);
                1: write_all(3, 2, 2, 64, 64, 64);
                2: write_all(1, 0, 1, 2, 3, 5);
                default: write_all($urandom_range(0, 6), $urandom_range(0, 6),
                                   $urandom_range(1, 3), $urandom_range(1, 64),
                                   $urandom_range(1, 64), $urandom_range(1, 64));
            endcase
            if (ph == 7) calm = 1;
            repeat (RANDOM_ITEMS / 8) random_beat();
        end

        in_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);

        $display("Sent %0d beats, checked %0d results, %0d refusals, %0d fragment queries.",
                 beats_in, beats_out, refusals, frag_queries);
        $display("Register settings covered quota and fanout extremes over eleven phases.");
        if (error_count == 0 && pending_answers.size() == 0)
            $display("fat_tree_usage_quota_table verification clean");
        else
            $display("fat_tree_usage_quota_table verification failed");
        $finish;
    end

endmodule
